[rtl/i2cm_pkg.sv]
// Shared types and constants for the I2C master register access engine.
// Used by the front end, the item queue, the back end and the top level.
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int MAX_BURST        = 16;
  localparam int QUEUE_DEPTH_DEF  = 4;
  localparam logic [6:0] DEV_ADDR_RESET = 7'd104;

  // Request codes as they arrive on the input channel.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Classified item kinds handed from the front end to the back end.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] reg_addr;
    logic [7:0] write_value;
    logic [4:0] burst_len;   // already clamped to 1..MAX_BURST
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] read_data;
    logic       byte_last;
    logic       done_res;
    logic       nack_error;
    logic       rejected;
  } res_t;

endpackage

[rtl/i2cm_front.sv]
// Front end: decodes the request code and clamps the burst length of each beat.
// Depends on i2cm_pkg for the item type and kind codes.
`timescale 1ns / 1ps

module i2cm_front
  import i2cm_pkg::*;
(
  input  logic [1:0] req_type,
  input  logic [7:0] reg_addr,
  input  logic [7:0] write_value,
  input  logic [4:0] burst_length,
  input  logic       sda_in,
  output item_t      item
);

  logic [4:0] len;

  always_comb begin
    if (burst_length == 5'd0) begin
      len = 5'd1;
    end else if (int'(burst_length) > MAX_BURST) begin
      len = 5'(MAX_BURST);
    end else begin
      len = burst_length;
    end
  end

  always_comb begin
    item.reg_addr    = reg_addr;
    item.write_value = write_value;
    item.burst_len   = len;
    item.sda_in      = sda_in;
    unique case (req_type)
      REQ_TICK:  item.kind = KIND_TICK;
      REQ_WRITE: item.kind = KIND_WRITE;
      REQ_READ:  item.kind = KIND_READ;
      default:   item.kind = KIND_NONE;
    endcase
  end

endmodule

[rtl/i2cm_queue.sv]
// Short first-in first-out queue of classified items between front and back end.
// Depends on i2cm_pkg for the item type.
`timescale 1ns / 1ps

module i2cm_queue
  import i2cm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign valid   = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/i2cm_back.sv]
// Back end: the bus sequencer that advances one half period per tick item,
// holding the device address register and the registered result beat.
// Depends on i2cm_pkg for item and result types.
`timescale 1ns / 1ps

module i2cm_back
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  input  logic       q_valid,
  input  item_t      q_head,
  output logic       q_pop,
  output logic       res_valid,
  output res_t       res,
  input  logic       res_ready
);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_START   = 4'd1;
  localparam logic [3:0] PH_ADDR_W  = 4'd2;
  localparam logic [3:0] PH_REG     = 4'd3;
  localparam logic [3:0] PH_VALUE   = 4'd4;
  localparam logic [3:0] PH_RESTART = 4'd5;
  localparam logic [3:0] PH_ADDR_R  = 4'd6;
  localparam logic [3:0] PH_READ    = 4'd7;
  localparam logic [3:0] PH_STOP    = 4'd8;

  logic [6:0] dev_addr_r;
  logic [3:0] phase_r, phase_nxt;
  logic [1:0] tick_r, tick_nxt;
  logic [3:0] bitc_r, bitc_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [4:0] bytec_r, bytec_nxt;
  logic       is_read_r, is_read_nxt;
  logic [4:0] total_r, total_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic [7:0] val_r, val_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       nack_r, nack_nxt;
  logic       res_valid_r;
  res_t       res_r, res_nxt;
  logic       last;
  logic       fire;

  assign fire      = q_valid && (!res_valid_r || res_ready);
  assign q_pop     = fire;
  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign last      = ({1'b0, bytec_r} + 6'd1) >= {1'b0, total_r};

  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    bitc_nxt    = bitc_r;
    shift_nxt   = shift_r;
    bytec_nxt   = bytec_r;
    is_read_nxt = is_read_r;
    total_nxt   = total_r;
    reg_nxt     = reg_r;
    val_nxt     = val_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    nack_nxt    = nack_r;
    res_nxt     = '0;

    unique case (q_head.kind)
      KIND_WRITE, KIND_READ: begin
        if (phase_r != PH_IDLE) begin
          res_nxt.rejected = 1'b1;
        end else begin
          reg_nxt     = q_head.reg_addr;
          val_nxt     = q_head.write_value;
          total_nxt   = q_head.burst_len;
          is_read_nxt = (q_head.kind == KIND_READ);
          nack_nxt    = 1'b0;
          bytec_nxt   = '0;
          bitc_nxt    = '0;
          phase_nxt   = PH_START;
          tick_nxt    = '0;
        end
      end
      KIND_TICK: begin
        unique case (phase_r)
          PH_START, PH_RESTART: begin
            unique case (tick_r)
              2'd0: begin sda_nxt = 1'b1; tick_nxt = 2'd1; end
              2'd1: begin scl_nxt = 1'b1; tick_nxt = 2'd2; end
              2'd2: begin sda_nxt = 1'b0; tick_nxt = 2'd3; end
              default: begin
                scl_nxt  = 1'b0;
                bitc_nxt = '0;
                tick_nxt = '0;
                if (phase_r == PH_START) begin
                  phase_nxt = PH_ADDR_W;
                  shift_nxt = {dev_addr_r, 1'b0};
                end else begin
                  phase_nxt = PH_ADDR_R;
                  shift_nxt = {dev_addr_r, 1'b1};
                end
              end
            endcase
          end
          PH_ADDR_W, PH_REG, PH_VALUE, PH_ADDR_R: begin
            if (tick_r == 2'd0) begin
              sda_nxt  = (bitc_r < 4'd8) ? shift_r[7] : 1'b1;
              tick_nxt = 2'd1;
            end else if (tick_r == 2'd1) begin
              scl_nxt  = 1'b1;
              tick_nxt = 2'd2;
            end else begin
              scl_nxt  = 1'b0;
              tick_nxt = '0;
              if (bitc_r < 4'd8) begin
                shift_nxt = {shift_r[6:0], 1'b0};
                bitc_nxt  = bitc_r + 4'd1;
              end else if (q_head.sda_in) begin
                // Target left SDA high in the acknowledge slot: abort.
                nack_nxt  = 1'b1;
                phase_nxt = PH_STOP;
              end else begin
                bitc_nxt = '0;
                unique case (phase_r)
                  PH_ADDR_W: begin
                    phase_nxt = PH_REG;
                    shift_nxt = reg_r;
                  end
                  PH_REG: begin
                    if (is_read_r) begin
                      phase_nxt = PH_RESTART;
                      bitc_nxt  = bitc_r;
                    end else begin
                      phase_nxt = PH_VALUE;
                      shift_nxt = val_r;
                    end
                  end
                  PH_ADDR_R: begin
                    phase_nxt = PH_READ;
                    shift_nxt = '0;
                    bytec_nxt = '0;
                  end
                  default: begin
                    phase_nxt = PH_STOP;
                    bitc_nxt  = bitc_r;
                  end
                endcase
              end
            end
          end
          PH_READ: begin
            if (tick_r == 2'd0) begin
              // Master releases SDA for data, and for the last byte's NACK.
              sda_nxt  = (bitc_r < 4'd8) ? 1'b1 : last;
              tick_nxt = 2'd1;
            end else if (tick_r == 2'd1) begin
              scl_nxt  = 1'b1;
              tick_nxt = 2'd2;
            end else begin
              scl_nxt  = 1'b0;
              tick_nxt = '0;
              if (bitc_r < 4'd8) begin
                shift_nxt = {shift_r[6:0], q_head.sda_in};
                bitc_nxt  = bitc_r + 4'd1;
                if (bitc_r == 4'd7) begin
                  res_nxt.byte_valid = 1'b1;
                  res_nxt.read_data  = {shift_r[6:0], q_head.sda_in};
                  res_nxt.byte_last  = last;
                end
              end else begin
                bytec_nxt = bytec_r + 5'd1;
                if (last) begin
                  phase_nxt = PH_STOP;
                end else begin
                  bitc_nxt  = '0;
                  shift_nxt = '0;
                end
              end
            end
          end
          PH_STOP: begin
            if (tick_r == 2'd0) begin
              sda_nxt  = 1'b0;
              tick_nxt = 2'd1;
            end else if (tick_r == 2'd1) begin
              scl_nxt  = 1'b1;
              tick_nxt = 2'd2;
            end else begin
              sda_nxt            = 1'b1;
              scl_nxt            = 1'b1;
              res_nxt.done_res   = 1'b1;
              res_nxt.nack_error = nack_r;
              phase_nxt          = PH_IDLE;
              tick_nxt           = '0;
              bitc_nxt           = '0;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            tick_nxt  = '0;
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
          end
        endcase
      end
      default: begin
        // Unused request code: no advance, levels held.
      end
    endcase

    res_nxt.scl_out  = scl_nxt;
    res_nxt.sda_out  = sda_nxt;
    res_nxt.busy_res = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= DEV_ADDR_RESET;
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      bitc_r      <= '0;
      shift_r     <= '0;
      bytec_r     <= '0;
      is_read_r   <= 1'b0;
      total_r     <= '0;
      reg_r       <= '0;
      val_r       <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      nack_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        dev_addr_r <= cfg_data;
      end
      if (fire) begin
        phase_r   <= phase_nxt;
        tick_r    <= tick_nxt;
        bitc_r    <= bitc_nxt;
        shift_r   <= shift_nxt;
        bytec_r   <= bytec_nxt;
        is_read_r <= is_read_nxt;
        total_r   <= total_nxt;
        reg_r     <= reg_nxt;
        val_r     <= val_nxt;
        scl_r     <= scl_nxt;
        sda_r     <= sda_nxt;
        nack_r    <= nack_nxt;
      end
      if (fire) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

endmodule

[rtl/i2c_master_register_access.sv]
// Top level of the I2C master register access engine.
// Instantiates i2cm_front, i2cm_queue and i2cm_back; uses i2cm_pkg.
//
// Usage: each input beat is a half-period tick (in_tuser 0), a register
// write command (1) or a burst read command (2). Every accepted input beat
// yields exactly one result beat carrying the SCL and SDA levels for the
// coming half period plus status flags; received bytes are flagged with
// byte_valid, and out_tlast marks the last byte of a read burst.
// The device address is written through the cfg channel, which is always
// ready; write it only while no transaction is under way.
// A beat is classified and written into the item queue at the edge it is
// accepted, and from the queue head it loads the result register, which
// drives out_tvalid. The sequencer takes one beat per cycle while the
// receiver does not stall the result register.
// When the receiver stalls, the result register holds and the queue
// (QUEUE_DEPTH beats) keeps taking input until it fills, then in_tready
// falls. Reset empties the queue and the result register, returns the bus
// levels to released and the device address to 104.
`timescale 1ns / 1ps

module i2c_master_register_access
  import i2cm_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // reg_addr[7:0], write_value[15:8],
                                  // burst_length[20:16], sda_in[21], zero pad
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // scl_out[0], sda_out[1], busy_res[2],
                                  // byte_valid[3], read_data[11:4], done_res[12],
                                  // nack_error[13], rejected[14], zero pad
  output logic        out_tlast,  // byte_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data    // device_address
);

  item_t front_item, q_head;
  logic  q_full, q_valid, q_pop;
  logic  res_valid;
  res_t  res;

  assign in_tready = !q_full;
  assign cfg_ready = 1'b1;

  i2cm_front u_front (
    .req_type     (in_tuser),
    .reg_addr     (in_tdata[7:0]),
    .write_value  (in_tdata[15:8]),
    .burst_length (in_tdata[20:16]),
    .sda_in       (in_tdata[21]),
    .item         (front_item)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  i2cm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (out_tready)
  );

  assign out_tvalid = res_valid;
  assign out_tlast  = res.byte_last;
  assign out_tdata  = {1'b0, res.rejected, res.nack_error, res.done_res,
                       res.read_data, res.byte_valid, res.busy_res,
                       res.sda_out, res.scl_out};

endmodule
